// ===== src/srpg_pkg.sv =====
// shared types and constants for the stepper ramp pulse generator
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package srpg_pkg;

	localparam int TICKS_PER_SECOND = 1000000;
	localparam int NUM_KEYS         = 8;

	localparam int KEY_W    = 8;
	localparam int ACCEL_W  = 10;
	localparam int SPEED_W  = 16;
	localparam int RAMP_W   = 16;
	localparam int PULSE_W  = 8;
	localparam int PERIOD_W = 20;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;

	localparam logic [PERIOD_W-1:0] DIV_DIVIDEND = PERIOD_W'(TICKS_PER_SECOND);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_STEP  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED   = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RAMP_TICKS  = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_PULSE_TICKS = 8'd3;

	localparam logic [ACCEL_W-1:0] ACCEL_RESET  = 10'd1;
	localparam logic [SPEED_W-1:0] MAXSPD_RESET = 16'd3000;
	localparam logic [RAMP_W-1:0]  RAMP_RESET   = 16'd1000;
	localparam logic [PULSE_W-1:0] PULSE_RESET  = 8'd5;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_PULSE,
		ST_OUT
	} seq_state_t;

	typedef struct packed {
		logic step_level;
		logic enable_level;
	} pulse_stat_t;

endpackage

`default_nettype wire

// ===== src/srpg_div.sv =====
// restoring divider: TICKS_PER_SECOND / divisor, one quotient bit per cycle
// depends on srpg_pkg
`timescale 1ns / 1ps
`default_nettype none

module srpg_div import srpg_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [SPEED_W-1:0] divisor,
	output logic                    busy,
	output logic                    done,
	output logic [PERIOD_W-1:0]     quotient
);

	localparam int CNT_W = $clog2(PERIOD_W);
	localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(PERIOD_W - 1);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [SPEED_W-1:0] rem_q;
	logic [SPEED_W-1:0] dvs_q;
	logic [PERIOD_W-1:0] quo_q;

	logic [SPEED_W:0]   shifted;
	logic [SPEED_W:0]   trial;
	logic               fits;
	logic [SPEED_W-1:0] rem_next;

	// quo_q shifts the dividend out at the top while quotient bits enter below
	always_comb begin
		shifted  = {rem_q, quo_q[PERIOD_W-1]};
		trial    = shifted - {1'b0, dvs_q};
		fits     = shifted >= {1'b0, dvs_q};
		rem_next = fits ? trial[SPEED_W-1:0] : shifted[SPEED_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == LAST_BIT) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= DIV_DIVIDEND;
		end else if (busy_q) begin
			rem_q <= rem_next;
			quo_q <= {quo_q[PERIOD_W-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

// ===== src/srpg_pulse.sv =====
// step pulse generator: latches a period, drives the pulse, runs one tick per fire
// depends on srpg_pkg
`timescale 1ns / 1ps
`default_nettype none

module srpg_pulse import srpg_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                fire,
	input  wire logic                speed_nz,
	input  wire logic [PERIOD_W-1:0] step_period,
	input  wire logic [PULSE_W-1:0]  pulse_ticks,
	output pulse_stat_t              stat
);

	logic                running_q;
	logic [PERIOD_W-1:0] phase_q;
	logic [PERIOD_W-1:0] latched_q;
	pulse_stat_t         stat_q;

	logic                start;
	logic                run;
	logic [PERIOD_W-1:0] pt_ext;
	logic [PERIOD_W-1:0] p_max;
	logic [PERIOD_W-1:0] p_lat;
	logic [PERIOD_W-1:0] lat;
	logic [PERIOD_W-1:0] ph;
	logic [PERIOD_W-1:0] ph_inc;
	logic                wrap;

	always_comb begin
		pt_ext = {{(PERIOD_W-PULSE_W){1'b0}}, pulse_ticks};
		start  = !running_q && speed_nz;
		run    = running_q || start;
		// period stretched to at least the pulse width, and never zero
		p_max  = (step_period < pt_ext) ? pt_ext : step_period;
		p_lat  = (p_max == '0) ? PERIOD_W'(1) : p_max;
		lat    = start ? p_lat : latched_q;
		ph     = start ? '0 : phase_q;
		ph_inc = ph + 1'b1;
		wrap   = ph_inc >= lat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			phase_q   <= '0;
			latched_q <= '0;
			stat_q    <= '{step_level: 1'b0, enable_level: 1'b1};
		end else if (fire) begin
			latched_q <= lat;
			stat_q.enable_level <= !run;
			stat_q.step_level   <= run && (ph < pt_ext);
			if (run) begin
				running_q <= !wrap;
				phase_q   <= wrap ? '0 : ph_inc;
			end
		end
	end

	assign stat = stat_q;

endmodule

`default_nettype wire

// ===== src/stepper_ramp_pulse_generator.sv =====
// top level: config registers, ramp timer, sequencer, output register
// depends on srpg_pkg, srpg_div, srpg_pulse
//
// channel  dir  handshake            payload
// in       in   in_valid / in_stall  key_levels_n
// out      out  out_valid / out_stall step_out, enable_n, speed, period_us
// cfg      in   cfg_valid / cfg_ready cfg_index, cfg_data
//
// a tick with no division: accept, pulse step, result beat
// a ramp update to a nonzero speed also passes through the divider state before the pulse step
// one tick at a time: in_stall is high from accept until the result beat leaves
// out_stall holds the result register; cfg_ready is always high
// reset clears the sequencer, ramp state and pulse generator to idle
`timescale 1ns / 1ps
`default_nettype none

module stepper_ramp_pulse_generator import srpg_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [KEY_W-1:0]      key_levels_n,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic                       step_out,
	output logic                       enable_n,
	output logic [SPEED_W-1:0]         speed,
	output logic [PERIOD_W-1:0]        period_us,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	logic [ACCEL_W-1:0]  accel_q;
	logic [SPEED_W-1:0]  max_speed_q;
	logic [RAMP_W-1:0]   ramp_ticks_q;
	logic [PULSE_W-1:0]  pulse_ticks_q;

	seq_state_t          state_q, state_d;
	logic [RAMP_W-1:0]   ramp_count_q;
	logic [SPEED_W-1:0]  velocity_q;
	logic [PERIOD_W-1:0] period_q;
	logic                out_valid_q;

	logic                in_acc;
	logic                out_acc;
	logic                pressed;
	logic [RAMP_W-1:0]   interval;
	logic [RAMP_W:0]     count_inc;
	logic                ramp_hit;
	logic [SPEED_W:0]    v_sum;
	logic [SPEED_W-1:0]  v_new;
	logic                div_start;
	logic                div_busy;
	logic                div_done;
	logic [PERIOD_W-1:0] div_quo;
	logic                fire;
	pulse_stat_t         pstat;

	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && !in_stall;
	assign out_acc   = out_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accel_q       <= ACCEL_RESET;
			max_speed_q   <= MAXSPD_RESET;
			ramp_ticks_q  <= RAMP_RESET;
			pulse_ticks_q <= PULSE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_ACCEL_STEP:  accel_q       <= cfg_data[ACCEL_W-1:0];
				CFG_MAX_SPEED:   max_speed_q   <= cfg_data[SPEED_W-1:0];
				CFG_RAMP_TICKS:  ramp_ticks_q  <= cfg_data[RAMP_W-1:0];
				CFG_PULSE_TICKS: pulse_ticks_q <= cfg_data[PULSE_W-1:0];
				default: ;
			endcase
		end
	end

	// ramp timer and speed step, evaluated in the accept cycle
	always_comb begin
		pressed   = key_levels_n[NUM_KEYS-1:0] != {NUM_KEYS{1'b1}};
		interval  = (ramp_ticks_q == '0) ? RAMP_W'(1) : ramp_ticks_q;
		count_inc = {1'b0, ramp_count_q} + 1'b1;
		ramp_hit  = count_inc >= {1'b0, interval};
		v_sum     = {1'b0, velocity_q} + {{(SPEED_W+1-ACCEL_W){1'b0}}, accel_q};
		if (pressed) begin
			v_new = (v_sum > {1'b0, max_speed_q}) ? max_speed_q : v_sum[SPEED_W-1:0];
		end else begin
			v_new = (velocity_q >= {{(SPEED_W-ACCEL_W){1'b0}}, accel_q})
				? velocity_q - {{(SPEED_W-ACCEL_W){1'b0}}, accel_q} : '0;
		end
		div_start = in_acc && ramp_hit && (v_new != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_count_q <= '0;
			velocity_q   <= '0;
			period_q     <= '0;
		end else begin
			if (in_acc) begin
				if (ramp_hit) begin
					ramp_count_q <= '0;
					velocity_q   <= v_new;
				end else begin
					ramp_count_q <= count_inc[RAMP_W-1:0];
				end
			end
			if (div_done) begin
				period_q <= div_quo;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		fire     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = div_start ? ST_DIV : ST_PULSE;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_PULSE;
				end
			end
			ST_PULSE: begin
				fire    = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_acc) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_acc) begin
			out_valid_q <= 1'b0;
		end
	end

	srpg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.divisor  (v_new),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	srpg_pulse u_pulse (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.speed_nz    (velocity_q != '0),
		.step_period (period_q),
		.pulse_ticks (pulse_ticks_q),
		.stat        (pstat)
	);

	assign out_valid = out_valid_q;
	assign step_out  = pstat.step_level;
	assign enable_n  = pstat.enable_level;
	assign speed     = velocity_q;
	assign period_us = period_q;

	// the divider is running for the whole of the divide state
	a_div_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> div_busy || div_done)
		else $error("divide state without active divider");

	// the period only moves when a division finishes
	a_period_src: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(period_q) |-> $past(div_done))
		else $error("period changed without division");

	// a result beat waits only in the output state
	a_out_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> state_q == ST_OUT)
		else $error("result valid outside output state");

	// an accepted tick always leaves idle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q != ST_IDLE)
		else $error("sequencer stayed idle after accept");

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// self-checking bench for stepper_ramp_pulse_generator: directed table, then random tick phases
// depends on srpg_pkg and the block's RTL; holds its own tick predictor for the ramp and pulse logic

module testbench;
	import srpg_pkg::*;

	localparam int CLK_PERIOD    = 10;
	localparam int RESET_CYCLES  = 5;
	localparam int RANDOM_ITEMS  = 1600;
	localparam int LONG_HOLD     = 400;
	localparam int WATCHDOG_MAX  = 4000;
	localparam int TAIL_CYCLES   = 40;

	localparam logic [KEY_W-1:0]     KEY_MASK = KEY_W'((64'd1 << NUM_KEYS) - 1);
	localparam logic [CFG_IDX_W-1:0] CFG_NONE = '1;

	typedef struct packed {
		logic                step_lvl;
		logic                enable_lvl;
		logic [SPEED_W-1:0]  speed_v;
		logic [PERIOD_W-1:0] period_v;
	} tick_result_t;

	typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;

	typedef struct {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] val;
		bit                    typed;
		tick_result_t          want;
	} script_row_t;

	typedef enum int {RUN_PRESS, RUN_RELEASE, RUN_NOISE} key_run_t;
	typedef enum int {STALL_NONE, STALL_COIN, STALL_THIRD, STALL_CHOKE} stall_mode_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [KEY_W-1:0] key_levels_n;
	logic out_valid;
	logic out_stall;
	logic step_out;
	logic enable_n;
	logic [SPEED_W-1:0] speed;
	logic [PERIOD_W-1:0] period_us;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// predictor copy of the registers and the ramp / pulse state
	logic [ACCEL_W-1:0]  accel_q     = ACCEL_RESET;
	logic [SPEED_W-1:0]  max_speed_q = MAXSPD_RESET;
	logic [RAMP_W-1:0]   ramp_q      = RAMP_RESET;
	logic [PULSE_W-1:0]  pulse_q     = PULSE_RESET;
	logic [RAMP_W-1:0]   ramp_cnt    = '0;
	logic [SPEED_W-1:0]  cur_speed   = '0;
	logic [PERIOD_W-1:0] cur_period  = '0;
	logic [PERIOD_W-1:0] phase_cnt   = '0;
	logic [PERIOD_W-1:0] held_period = '0;
	bit                  pulsing     = 1'b0;

	tick_result_t expected_ticks [$];
	script_row_t  script [$];
	int errors = 0;
	int beats_out = 0;
	int burst_left = 0;
	int idle_cycles = 0;

	stepper_ramp_pulse_generator u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.key_levels_n (key_levels_n),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.step_out     (step_out),
		.enable_n     (enable_n),
		.speed        (speed),
		.period_us    (period_us),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// one tick: ramp update first, then the pulse generator sees the new speed
	function automatic tick_result_t advance_tick(input logic [KEY_W-1:0] keys);
		tick_result_t r;
		int interval;
		int v;
		bit pressed;
		pressed = (keys & KEY_MASK) != KEY_MASK;
		interval = (ramp_q == 0) ? 1 : int'(ramp_q);
		if (int'(ramp_cnt) + 1 >= interval) begin
			ramp_cnt = '0;
			if (pressed) begin
				v = int'(cur_speed) + int'(accel_q);
				if (v > int'(max_speed_q))
					v = int'(max_speed_q);
			end else begin
				v = (cur_speed >= accel_q) ? int'(cur_speed) - int'(accel_q) : 0;
			end
			cur_speed = v[SPEED_W-1:0];
			if (cur_speed != 0)
				cur_period = PERIOD_W'(TICKS_PER_SECOND / int'(cur_speed));
		end else begin
			ramp_cnt = ramp_cnt + 1'b1;
		end
		if (!pulsing && cur_speed != 0) begin
			v = int'(cur_period);
			if (v < int'(pulse_q))
				v = int'(pulse_q);
			if (v == 0)
				v = 1;
			held_period = v[PERIOD_W-1:0];
			phase_cnt = '0;
			pulsing = 1'b1;
		end
		r = '{1'b0, 1'b1, cur_speed, cur_period};
		if (pulsing) begin
			r.enable_lvl = 1'b0;
			r.step_lvl = phase_cnt < pulse_q;
			phase_cnt = phase_cnt + 1'b1;
			if (phase_cnt >= held_period) begin
				phase_cnt = '0;
				pulsing = 1'b0;
			end
		end
		return r;
	endfunction

	function automatic void tick_row(input logic [KEY_W-1:0] keys);
		script.push_back('{ROW_TICK, '0, CFG_DATA_W'(keys), 1'b0, '0});
	endfunction

	function automatic void checked_row(input logic [KEY_W-1:0] keys, input tick_result_t want);
		script.push_back('{ROW_TICK, '0, CFG_DATA_W'(keys), 1'b1, want});
	endfunction

	function automatic void write_row(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		script.push_back('{ROW_WRITE, idx, val, 1'b0, '0});
	endfunction

	// leaves cfg_valid high; the next tick beat lowers it
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			CFG_ACCEL_STEP:  accel_q = data[ACCEL_W-1:0];
			CFG_MAX_SPEED:   max_speed_q = data[SPEED_W-1:0];
			CFG_RAMP_TICKS:  ramp_q = data[RAMP_W-1:0];
			CFG_PULSE_TICKS: pulse_q = data[PULSE_W-1:0];
			default: ;
		endcase
	endtask

	task automatic send_tick(input logic [KEY_W-1:0] keys, input bit typed,
			input tick_result_t typed_want);
		tick_result_t want;
		int gap;
		key_levels_n <= keys;
		in_valid <= 1'b1;
		cfg_valid <= 1'b0;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		want = advance_tick(keys);
		expected_ticks.push_back(typed ? typed_want : want);
		// sender works in bursts, gaps of varying length land on every phase of the block
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_ticks.size() != 0)
			@(posedge clk);
	endtask

	// stimulus
	initial begin
		int n_phase;
		int run_len;
		int random_items;
		int pick;
		key_run_t run_kind;
		logic [KEY_W-1:0] keys;
		logic [CFG_DATA_W-1:0] word;

		arst_n <= 1'b0;
		in_valid <= 1'b0;
		key_levels_n <= '1;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;

		checked_row(8'hFF, '{1'b0, 1'b1, 16'd0, 20'd0});
		// key down, but the ramp interval has not elapsed yet
		checked_row(8'h00, '{1'b0, 1'b1, 16'd0, 20'd0});
		write_row(CFG_NONE, 16'hFFFF);
		write_row(CFG_RAMP_TICKS, 16'h0000);
		write_row(CFG_ACCEL_STEP, 16'hFFFF);
		write_row(CFG_MAX_SPEED, 16'hFFFF);
		write_row(CFG_PULSE_TICKS, 16'hFFFF);
		tick_row(8'h7F);
		tick_row(8'hFE);
		tick_row(8'h00);
		// ramp back down to zero while the latched period keeps running
		tick_row(8'hFF);
		tick_row(8'hFF);
		tick_row(8'hFF);
		write_row(CFG_MAX_SPEED, 16'h0000);
		tick_row(8'h00);
		write_row(CFG_MAX_SPEED, 16'd3000);
		write_row(CFG_ACCEL_STEP, 16'h0000);
		tick_row(8'h00);
		write_row(CFG_ACCEL_STEP, 16'd1);
		write_row(CFG_PULSE_TICKS, 16'h0000);
		tick_row(8'h00);
		tick_row(8'h00);
		// interval raised, then lowered below the running count
		write_row(CFG_RAMP_TICKS, 16'd1000);
		tick_row(8'h00);
		tick_row(8'h00);
		tick_row(8'h00);
		write_row(CFG_RAMP_TICKS, 16'd2);
		tick_row(8'h00);
		write_row(CFG_RAMP_TICKS, 16'hFFFF);
		write_row(CFG_PULSE_TICKS, 16'h0001);
		write_row(CFG_ACCEL_STEP, 16'd1000);
		write_row(CFG_MAX_SPEED, 16'hFFFF);
		tick_row(8'h00);
		tick_row(8'hFF);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < script.size(); i++) begin
			if (script[i].kind == ROW_WRITE) begin
				wait_idle();
				write_reg(script[i].idx, script[i].val);
			end else begin
				send_tick(script[i].val[KEY_W-1:0], script[i].typed, script[i].want);
			end
		end

		random_items = 0;
		while (random_items < RANDOM_ITEMS) begin
			wait_idle();
			word = CFG_DATA_W'($urandom);
			case ($urandom_range(0, 9))
				0: word[ACCEL_W-1:0] = '0;
				1: word[ACCEL_W-1:0] = '1;
				2: word[ACCEL_W-1:0] = ACCEL_W'(1);
				default: word[ACCEL_W-1:0] = ACCEL_W'($urandom_range(1, 1000));
			endcase
			write_reg(CFG_ACCEL_STEP, word);
			case ($urandom_range(0, 9))
				0: word = '0;
				1, 2: word = '1;
				3, 4, 5: word = CFG_DATA_W'($urandom_range(1, 300));
				default: word = CFG_DATA_W'($urandom_range(1, 65535));
			endcase
			write_reg(CFG_MAX_SPEED, word);
			case ($urandom_range(0, 19))
				0, 1: word = '0;
				2: word = '1;
				3, 4, 5, 6: word = CFG_DATA_W'($urandom_range(5, 60));
				default: word = CFG_DATA_W'($urandom_range(1, 4));
			endcase
			write_reg(CFG_RAMP_TICKS, word);
			word = CFG_DATA_W'($urandom);
			case ($urandom_range(0, 9))
				0: word[PULSE_W-1:0] = '0;
				1: word[PULSE_W-1:0] = '1;
				2, 3, 4, 5, 6: word[PULSE_W-1:0] = PULSE_W'($urandom_range(1, 8));
				default: word[PULSE_W-1:0] = PULSE_W'($urandom_range(1, 255));
			endcase
			write_reg(CFG_PULSE_TICKS, word);
			if ($urandom_range(0, 7) == 0)
				write_reg(CFG_IDX_W'($urandom_range(int'(CFG_PULSE_TICKS) + 1, 255)),
					CFG_DATA_W'($urandom));

			// press / release runs with random key patterns, a little noise
			n_phase = $urandom_range(20, 90);
			while (n_phase > 0 && random_items < RANDOM_ITEMS) begin
				pick = $urandom_range(0, 19);
				run_kind = (pick < 11) ? RUN_PRESS : (pick < 18) ? RUN_RELEASE : RUN_NOISE;
				run_len = $urandom_range(1, 40);
				for (int i = 0; i < run_len && n_phase > 0; i++) begin
					case (run_kind)
						RUN_PRESS: begin
							keys = KEY_W'($urandom);
							if (keys == KEY_MASK)
								keys[$urandom_range(0, KEY_W - 1)] = 1'b0;
						end
						RUN_RELEASE: keys = KEY_MASK;
						default: keys = KEY_W'($urandom);
					endcase
					send_tick(keys, 1'b0, '0);
					n_phase--;
					random_items++;
				end
			end
		end

		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// result side stall patterns, plus one long hold while the sender keeps offering
	initial begin
		int len;
		bit held_long;
		stall_mode_t mode;
		out_stall <= 1'b0;
		held_long = 1'b0;
		while (arst_n !== 1'b1)
			@(posedge clk);
		forever begin
			mode = stall_mode_t'($urandom_range(0, 3));
			len = $urandom_range(5, 120);
			for (int k = 0; k < len; k++) begin
				@(posedge clk);
				case (mode)
					STALL_NONE:  out_stall <= 1'b0;
					STALL_COIN:  out_stall <= 1'($urandom_range(0, 1));
					STALL_THIRD: out_stall <= (k % 3) == 2;
					default:     out_stall <= $urandom_range(0, 4) != 0;
				endcase
			end
			if (!held_long && beats_out >= 300 && in_valid) begin
				held_long = 1'b1;
				@(posedge clk);
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		tick_result_t got;
		tick_result_t want;
		if (arst_n === 1'b1 && out_valid && !out_stall) begin
			beats_out++;
			got = '{step_out, enable_n, speed, period_us};
			if (expected_ticks.size() == 0) begin
				$display("%0t: result beat with nothing expected, got %p", $time, got);
				errors++;
			end else begin
				want = expected_ticks.pop_front();
				if (got.step_lvl !== want.step_lvl) begin
					$display("%0t: step_out expected %0d got %0d", $time, want.step_lvl,
						got.step_lvl);
					errors++;
				end
				if (got.enable_lvl !== want.enable_lvl) begin
					$display("%0t: enable_n expected %0d got %0d", $time, want.enable_lvl,
						got.enable_lvl);
					errors++;
				end
				if (got.speed_v !== want.speed_v) begin
					$display("%0t: speed expected %0d got %0d", $time, want.speed_v,
						got.speed_v);
					errors++;
				end
				if (got.period_v !== want.period_v) begin
					$display("%0t: period_us expected %0d got %0d", $time, want.period_v,
						got.period_v);
					errors++;
				end
			end
		end
	end

	// watchdog: cycles without any beat on any channel
	always @(posedge clk) begin
		if (arst_n !== 1'b1 || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_MAX) begin
				$display("%0t: no beat for %0d cycles", $time, WATCHDOG_MAX);
				$display("status: fail");
				$finish;
			end
		end
	end

endmodule
